@@ design/mtg_pkg.sv @@
// Shared types, constants and word functions for the MT19937 generator core.
// No dependencies.
package mtg_pkg;

    localparam int unsigned N_WORDS = 624;
    localparam int unsigned FAR_TAP = 397;
    localparam int unsigned POS_W = 10;

    localparam logic [31:0] TWIST_XOR   = 32'h9908_b0df;
    localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS    = 32'h7fff_ffff;
    localparam logic [31:0] SEED_MULT   = 32'd1812433253;
    localparam logic [31:0] MIX1_MULT   = 32'd1664525;
    localparam logic [31:0] MIX2_MULT   = 32'd1566083941;
    localparam logic [31:0] KEY_BASE    = 32'd19650218;
    localparam logic [31:0] DFLT_SEED   = 32'd5489;
    localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(N_WORDS - 1);
    localparam logic [POS_W-1:0] MIX1_LAST  = POS_W'(N_WORDS - 1);
    localparam logic [POS_W-1:0] MIX2_LAST  = POS_W'(N_WORDS - 2);

    typedef enum logic [1:0] {
        CMD_NEXT   = 2'd0,
        CMD_SEED   = 2'd1,
        CMD_KEY    = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEED,
        PH_MIX1,
        PH_MIX2,
        PH_FIN,
        PH_ALIGN,
        PH_GEN
    } t_phase;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] fold30(input logic [31:0] p);
        return p ^ (p >> 30);
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] far);
        logic [31:0] y;
        y = (a & TOP_BIT) | (b & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ design/mtg_cell.sv @@
// One state word of the twister ring; loads its neighbor's word on shift.
// Depends on nothing.
module mtg_cell (
    input  logic        i_clk,
    input  logic        i_shift,
    input  logic [31:0] i_word,
    output logic [31:0] o_word
);
    logic [31:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;
endmodule

@@ design/mtg_chain.sv @@
// Ring of 624 word cells; cell 0 is the oldest word, new words enter at the tail.
// Depends on mtg_pkg and mtg_cell.
module mtg_chain (
    input  logic        i_clk,
    input  logic        i_shift,
    input  logic [31:0] i_word,
    output logic [31:0] o_tap0,
    output logic [31:0] o_tap1,
    output logic [31:0] o_tapm
);
    import mtg_pkg::*;

    logic [31:0] w_word [N_WORDS];

    genvar gi;
    generate
        for (gi = 0; gi < N_WORDS; gi++) begin : g_cell
            if (gi == N_WORDS - 1) begin : g_tail
                mtg_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(i_shift),
                    .i_word (i_word),
                    .o_word (w_word[gi])
                );
            end else begin : g_body
                mtg_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(i_shift),
                    .i_word (w_word[gi+1]),
                    .o_word (w_word[gi])
                );
            end
        end
    endgenerate

    assign o_tap0 = w_word[0];
    assign o_tap1 = w_word[1];
    assign o_tapm = w_word[FAR_TAP];
endmodule

@@ design/mt19937_generator_core.sv @@
// MT19937 generator top level: command decode, seeding sequencer and tempering.
// Depends on mtg_pkg and mtg_chain.
//
// Usage: a command word is taken on a clock edge with start high and busy low.
//   i_cmd = 0 draws the next word; 1 seeds from i_value; 2 appends i_value to
//   the key store, and with i_last set also seeds from the stored key array.
//   Command 3 is ignored.
// Results: o_valid pulses for one cycle with o_random_word; the receiver
//   cannot stall, so every result must be taken in that cycle.
// Latency and throughput: a draw from a seeded ring gives its word on the
//   cycle after acceptance with busy staying low, so draws go one per cycle.
//   The 624-word ring is twisted lazily: cell 0 is twisted as it leaves the
//   head and re-enters at the tail, so no full regeneration pass exists.
// Value seeding: busy for one ring rotation, one multiply per word.
// A draw on an unseeded block first seeds with 5489, stays busy for the seeding
//   pass and one generate step, and its word shows as busy falls.
// Key seeding: a seed pass, two mixing passes (wrap steps included), a pass
//   to write word 0 and a rotation back to alignment. busy is high throughout.
// Reset: the ring is unseeded and the key store empty; ring contents are
//   don't-care until the first seeding writes them.
module mt19937_generator_core #(
    parameter int KEY_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_value,
    input  logic        i_last,
    output logic        o_valid,
    output logic [31:0] o_random_word
);
    import mtg_pkg::*;

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CW = $clog2(KEY_MAX + 1);
    localparam logic [CW-1:0] KEY_FULL = CW'(KEY_MAX);

    // sequencer state
    t_phase         r_phase, n_phase;
    t_phase         r_after;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_k;
    logic [KW-1:0]  r_j, n_j;
    logic [31:0]    r_prev;
    logic [31:0]    r_seed;
    logic           r_seeded;
    logic [CW-1:0]  r_key_cnt;
    logic [CW-1:0]  r_len;
    logic [31:0]    r_key_q;
    logic [31:0]    key_mem [KEY_MAX];

    logic           r_valid;
    logic [31:0]    r_word;

    // datapath
    logic [31:0]    w_tap0, w_tap1, w_tapm;
    logic [31:0]    w_push;
    logic [31:0]    w_twist;
    logic           w_shift;
    logic           w_take;
    logic           w_draw;
    logic           w_seed_go;
    logic [CW-1:0]  w_cnt_inc;
    logic [CW-1:0]  w_j_inc;

    assign w_take    = start && !busy;
    assign w_draw    = w_take && (t_cmd'(i_cmd) == CMD_NEXT) && r_seeded;
    assign w_cnt_inc = (r_key_cnt < KEY_FULL) ? r_key_cnt + CW'(1) : r_key_cnt;
    assign w_j_inc   = CW'(r_j) + CW'(1);
    assign w_twist   = twist(w_tap0, w_tap1, w_tapm);

    always_comb begin
        w_seed_go = 1'b0;
        if (w_take) begin
            unique case (t_cmd'(i_cmd))
                CMD_NEXT:   w_seed_go = !r_seeded;
                CMD_SEED:   w_seed_go = 1'b1;
                CMD_KEY:    w_seed_go = i_last;
                CMD_UNUSED: w_seed_go = 1'b0;
                default:    w_seed_go = 1'b0;
            endcase
        end
    end

    mtg_chain u_chain (
        .i_clk (i_clk),
        .i_shift(w_shift),
        .i_word(w_push),
        .o_tap0(w_tap0),
        .o_tap1(w_tap1),
        .o_tapm(w_tapm)
    );

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE:  if (w_seed_go) n_phase = PH_SEED;
            PH_SEED:  if (r_pos == POS_LAST) n_phase = r_after;
            PH_MIX1:  if (r_pos != '0 && r_k == MIX1_LAST) n_phase = PH_MIX2;
            PH_MIX2:  if (r_pos != '0 && r_k == MIX2_LAST) n_phase = PH_FIN;
            PH_FIN:   if (r_pos == '0) n_phase = PH_ALIGN;
            PH_ALIGN: if (r_pos == POS_LAST) n_phase = PH_IDLE;
            PH_GEN:   n_phase = PH_IDLE;
            default:  n_phase = PH_IDLE;
        endcase
    end

    // word pushed into the ring tail and shift enable
    always_comb begin
        w_push  = w_tap0;
        w_shift = 1'b1;
        unique case (r_phase)
            PH_IDLE: begin
                w_push  = w_twist;
                w_shift = w_draw;
            end
            PH_SEED: begin
                w_push = (r_pos == '0) ? r_seed
                       : mul32(SEED_MULT, fold30(r_prev)) + 32'(r_pos);
            end
            PH_MIX1: begin
                if (r_pos == '0) begin
                    // first visit keeps word 0; later wraps copy the last word
                    w_push = (r_k == '0) ? w_tap0 : r_prev;
                end else begin
                    w_push = (w_tap0 ^ mul32(fold30(r_prev), MIX1_MULT))
                           + r_key_q + 32'(r_j);
                end
            end
            PH_MIX2: begin
                w_push = (r_pos == '0) ? r_prev
                       : (w_tap0 ^ mul32(fold30(r_prev), MIX2_MULT)) - 32'(r_pos);
            end
            PH_FIN:   w_push = (r_pos == '0) ? TOP_BIT : w_tap0;
            PH_ALIGN: w_push = w_tap0;
            PH_GEN:   w_push = w_twist;
            default:  w_push = w_tap0;
        endcase
    end

    always_comb begin
        n_j = r_j;
        if (r_phase == PH_IDLE) begin
            n_j = '0;
        end else if (r_phase == PH_MIX1 && r_pos != '0) begin
            n_j = (w_j_inc == r_len) ? '0 : KW'(w_j_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_seeded  <= 1'b0;
            r_key_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= w_draw || (r_phase == PH_GEN);
            if (w_seed_go) begin
                r_seeded <= 1'b1;
            end
            if (w_take && t_cmd'(i_cmd) == CMD_KEY) begin
                r_key_cnt <= i_last ? '0 : w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_key_q <= key_mem[n_j];
        r_word  <= temper(w_twist);
        if (w_shift) begin
            r_prev <= w_push;
        end
        if (w_take && t_cmd'(i_cmd) == CMD_KEY && r_key_cnt < KEY_FULL) begin
            key_mem[r_key_cnt[KW-1:0]] <= i_value;
        end
        if (w_seed_go) begin
            r_pos <= '0;
            r_k   <= '0;
            unique case (t_cmd'(i_cmd))
                CMD_SEED: begin
                    r_seed  <= i_value;
                    r_after <= PH_IDLE;
                end
                CMD_KEY: begin
                    r_seed  <= KEY_BASE;
                    r_after <= PH_MIX1;
                    r_len   <= w_cnt_inc;
                end
                default: begin
                    r_seed  <= DFLT_SEED;
                    r_after <= PH_GEN;
                end
            endcase
        end else if (r_phase != PH_IDLE && r_phase != PH_GEN) begin
            r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
            if ((r_phase == PH_MIX1 || r_phase == PH_MIX2) && r_pos != '0) begin
                r_k <= (n_phase != r_phase) ? '0 : r_k + POS_W'(1);
            end
        end
    end

    assign busy          = (r_phase != PH_IDLE);
    assign o_valid       = r_valid;
    assign o_random_word = r_word;
endmodule

@@ design/mtg_checker.sv @@
// Port-level checks for the MT19937 generator core, bound to the top level.
// Depends on mtg_pkg and mt19937_generator_core.
module mtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_cmd,
    input logic        i_last,
    input logic        o_valid
);
    import mtg_pkg::*;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_seed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_SEED) |=> busy)
        else $error("seed command did not start seeding");

    a_unused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_UNUSED) |=> (!busy && !o_valid))
        else $error("unused command had an effect");

    a_key_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_KEY && !i_last) |=> (!busy && !o_valid))
        else $error("key append was not silent");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(busy) && !($past(start) && $past(i_cmd) == CMD_NEXT)) |-> !o_valid)
        else $error("result without a draw");
endmodule

bind mt19937_generator_core mtg_checker u_mtg_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_cmd  (i_cmd),
    .i_last (i_last),
    .o_valid(o_valid)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for mt19937_generator_core: directed table, then random commands.
// Depends on mtg_pkg (command codes) and the design top level; predicts every word itself.
module tb;
    import mtg_pkg::*;

    localparam int RING_LEN  = 624;
    localparam int FAR_OFS   = 397;
    localparam int KEY_SLOTS = 16;
    localparam int RAND_WORDS = 1150;
    localparam int QUIET_TAIL = 150;   // final stretch of the run with no gaps

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [31:0] i_value;
    logic        i_last;
    logic        o_valid;
    logic [31:0] o_random_word;

    mt19937_generator_core #(.KEY_MAX(KEY_SLOTS)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_value(i_value),
        .i_last(i_last),
        .o_valid(o_valid),
        .o_random_word(o_random_word)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the twister ring and key store.
    // pos == RING_LEN+1 means never seeded; RING_LEN means regenerate next.
    // ------------------------------------------------------------------
    logic [31:0] ring[RING_LEN];
    int unsigned pos;
    logic [31:0] key_words[KEY_SLOTS];
    int unsigned key_fill;

    logic [31:0] expected_words[$];   // drawn words not yet seen on the output
    int errors;

    function automatic logic [31:0] lo_mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic logic [31:0] spread(input logic [31:0] p);
        return p ^ {30'd0, p[31:30]};
    endfunction

    // Linear recurrence fill from one 32-bit seed.
    task automatic fill_from_value(input logic [31:0] s);
        ring[0] = s;
        for (int n = 1; n < RING_LEN; n++)
            ring[n] = lo_mul(32'd1812433253, spread(ring[n-1])) + n;
        pos = RING_LEN;
    endtask

    // Key-array seeding: base fill, then two mixing passes over the ring.
    task automatic fill_from_keys(input int unsigned len);
        int unsigned r;
        int unsigned k;
        int unsigned cnt;
        r = 1;
        k = 0;
        fill_from_value(32'd19650218);
        cnt = (RING_LEN > len) ? RING_LEN : len;
        repeat (cnt) begin
            ring[r] = (ring[r] ^ lo_mul(spread(ring[r-1]), 32'd1664525)) + key_words[k] + k;
            r++;
            k++;
            if (r >= RING_LEN) begin
                ring[0] = ring[RING_LEN-1];
                r = 1;
            end
            if (k >= len)
                k = 0;
        end
        repeat (RING_LEN - 1) begin
            ring[r] = (ring[r] ^ lo_mul(spread(ring[r-1]), 32'd1566083941)) - r;
            r++;
            if (r >= RING_LEN) begin
                ring[0] = ring[RING_LEN-1];
                r = 1;
            end
        end
        ring[0] = 32'h8000_0000;
        pos = RING_LEN;
    endtask

    function automatic logic [31:0] mix_pair(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] far);
        logic [31:0] y;
        y = {a[31], b[30:0]};
        return far ^ (y >> 1) ^ (y[0] ? 32'h9908_b0df : 32'd0);
    endfunction

    task automatic regenerate_ring();
        for (int n = 0; n < RING_LEN - 1; n++)
            ring[n] = mix_pair(ring[n], ring[n+1], ring[(n + FAR_OFS) % RING_LEN]);
        ring[RING_LEN-1] = mix_pair(ring[RING_LEN-1], ring[0], ring[FAR_OFS-1]);
        pos = 0;
    endtask

    task automatic draw_tempered(output logic [31:0] w);
        logic [31:0] y;
        if (pos >= RING_LEN) begin
            if (pos != RING_LEN)
                fill_from_value(32'd5489);
            regenerate_ring();
        end
        y = ring[pos];
        pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        w = y;
    endtask

    // Apply one accepted command word to the predictor; queue any result.
    task automatic predict_word(input t_cmd c, input logic [31:0] v, input logic l);
        logic [31:0] w;
        case (c)
            CMD_NEXT: begin
                draw_tempered(w);
                expected_words.push_back(w);
            end
            CMD_SEED: fill_from_value(v);
            CMD_KEY: begin
                // a full store drops the word, but last still triggers seeding
                if (key_fill < KEY_SLOTS) begin
                    key_words[key_fill] = v;
                    key_fill++;
                end
                if (l && key_fill != 0) begin
                    fill_from_keys(key_fill);
                    key_fill = 0;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("mt19937_generator_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result checker: o_valid is a one-cycle strobe, so sample every edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time,
                         o_random_word);
                errors++;
            end else begin
                if (o_random_word !== expected_words[0]) begin
                    $display("%0t: random_word mismatch, expected %h, actual %h", $time,
                             expected_words[0], o_random_word);
                    errors++;
                end
                void'(expected_words.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver: hold start until the word is taken (start & !busy).
    // Called at a clock edge, returns at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_word(input t_cmd c, input logic [31:0] v, input logic l);
        start   <= 1'b1;
        i_cmd   <= c;
        i_value <= v;
        i_last  <= l;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        predict_word(c, v, l);
    endtask

    task automatic maybe_gap(input bit allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Directed table; chk marks rows whose answer is known outright.
    typedef struct {
        t_cmd        cmd;
        logic [31:0] value;
        logic        last;
        bit          chk;
        logic [31:0] want;
    } t_row;

    t_row rows[] = '{
        // first draw on an unseeded block: default seed, well-known first word
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b1, 32'hd091_bb5c},
        '{CMD_NEXT,   32'hffff_ffff, 1'b1, 1'b0, 32'd0},   // last ignored
        '{CMD_UNUSED, 32'hffff_ffff, 1'b1, 1'b0, 32'd0},   // unused command
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_SEED,   32'h0000_0000, 1'b1, 1'b0, 32'd0},
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_SEED,   32'hffff_ffff, 1'b0, 1'b0, 32'd0},
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_SEED,   32'h0000_1571, 1'b0, 1'b0, 32'd0},   // 5489 explicitly
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_KEY,    32'h0000_0123, 1'b0, 1'b0, 32'd0},
        '{CMD_KEY,    32'h0000_0234, 1'b0, 1'b0, 32'd0},
        '{CMD_KEY,    32'h0000_0345, 1'b0, 1'b0, 32'd0},
        '{CMD_KEY,    32'h0000_0456, 1'b1, 1'b0, 32'd0},
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_KEY,    32'hffff_ffff, 1'b1, 1'b0, 32'd0},   // one-word key
        '{CMD_NEXT,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
        '{CMD_KEY,    32'h0000_0000, 1'b1, 1'b0, 32'd0},
        '{CMD_NEXT,   32'hffff_ffff, 1'b1, 1'b0, 32'd0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned roll;
        t_cmd c;
        errors   = 0;
        pos      = RING_LEN + 1;
        key_fill = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= CMD_NEXT;
        i_value <= 32'd0;
        i_last  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            send_word(rows[r].cmd, rows[r].value, rows[r].last);
            // a known answer replaces the predicted one in the queue
            if (rows[r].chk)
                expected_words[expected_words.size()-1] = rows[r].want;
            maybe_gap(1'b1);
        end

        // Overfill the key store: two words past capacity, last on a dropped one.
        for (int k = 0; k < KEY_SLOTS + 2; k++)
            send_word(CMD_KEY, $urandom, k == KEY_SLOTS + 1);
        send_word(CMD_NEXT, 32'd0, 1'b0);

        // Random part: mostly draws so the ring wraps and regenerates often.
        for (int n = 0; n < RAND_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 84)
                c = CMD_NEXT;
            else if (roll < 88)
                c = CMD_SEED;
            else if (roll < 97)
                c = CMD_KEY;
            else
                c = CMD_UNUSED;
            send_word(c, $urandom, ($urandom_range(0, 3) == 0));
            if (n == RAND_WORDS / 2) begin
                // drain completely before going on
                start <= 1'b0;
                do
                    @(posedge i_clk);
                while (expected_words.size() != 0 || busy);
            end else begin
                maybe_gap(n < RAND_WORDS - QUIET_TAIL);
            end
        end
        start <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge i_clk);
        // allow a trailing key seeding to finish and any stray word to show up
        repeat (3200) @(posedge i_clk);

        if (errors == 0 && expected_words.size() == 0)
            $display("mt19937_generator_core verification clean");
        else
            $display("mt19937_generator_core verification failed");
        $finish;
    end

endmodule
